>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types of the sorted priority queue
// Opcodes, status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Operation carried by a request word
	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_POP_HIGH = 2'd1,
		OP_POP_LOW  = 2'd2,
		OP_REMOVE   = 2'd3
	} op_t;

	// Status returned in every response word
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_SHIFT  = 2'd1,
		CELL_INSERT = 2'd2
	} cell_op_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} fsm_t;

endpackage

>>> hdl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready channel carrying opcode, id and priority of one request word.
// ----------------------------------------------------------------------------
interface spq_req_if #(
	parameter int ID_BITS       = 16,
	parameter int PRIORITY_BITS = 8
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [ID_BITS-1:0]       item_id;
	logic [PRIORITY_BITS-1:0] priority_req;

	modport source (output valid, output opcode, output item_id, output priority_req,
		input ready);
	modport sink (input valid, input opcode, input item_id, input priority_req,
		output ready);
endinterface

>>> hdl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready channel carrying status, id and priority of one response word.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
	parameter int ID_BITS       = 16,
	parameter int PRIORITY_BITS = 8
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [ID_BITS-1:0]       out_id;
	logic [PRIORITY_BITS-1:0] out_priority;

	modport source (output valid, output status, output out_id, output out_priority,
		input ready);
	modport sink (input valid, input status, input out_id, input out_priority,
		output ready);
endinterface

>>> hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, compares it with the broadcast priority, and on command
// keeps it, takes its right neighbor, or takes the new entry or its left one.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
	parameter int ID_BITS       = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_op_t                 op,
	input  logic [ID_BITS-1:0]       new_id,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic                     left_ge,
	input  logic                     left_valid,
	input  logic [ID_BITS-1:0]       left_id,
	input  logic [PRIORITY_BITS-1:0] left_prio,
	input  logic                     right_valid,
	input  logic [ID_BITS-1:0]       right_id,
	input  logic [PRIORITY_BITS-1:0] right_prio,
	output logic                     valid,
	output logic [ID_BITS-1:0]       id,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic                     ge
);

	logic                     valid_q;
	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic                     valid_d;
	logic [ID_BITS-1:0]       id_d;
	logic [PRIORITY_BITS-1:0] prio_d;

	// Entry stays ahead of a new one of equal priority
	assign ge = valid_q && (prio_q >= new_prio);

	// Select the next content of the slot
	always_comb begin
		valid_d = valid_q;
		id_d    = id_q;
		prio_d  = prio_q;
		case (op)
			CELL_HOLD: begin
			end
			CELL_SHIFT: begin
				valid_d = right_valid;
				id_d    = right_id;
				prio_d  = right_prio;
			end
			CELL_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						valid_d = 1'b1;
						id_d    = new_id;
						prio_d  = new_prio;
					end else begin
						valid_d = left_valid;
						id_d    = left_id;
						prio_d  = left_prio;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Hold the entry payload
	always_ff @(posedge clk) begin
		id_q   <= id_d;
		prio_q <= prio_d;
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign prio  = prio_q;

endmodule

>>> hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept sorted in a chain of cells
// Up to DEPTH (id, priority) entries, highest priority at the front, equal
// priorities in arrival order.
//
// Usage:
// - req channel: one word per operation (insert, pop highest, pop lowest,
//   remove by id). rsp channel: exactly one word per request, in order,
//   with status, id and priority of the removed entry (zero when none).
// - Insert and pop highest act in the cycle that accepts them: the whole
//   chain compares against the request in parallel. Their response word is
//   registered into the output buffer, and a new request is taken every
//   cycle while the buffer's second word is free.
// - Pop lowest and remove by id rotate the chain past its front cell, one
//   slot per cycle for a full turn, taking no request until the turn ends.
//   An empty queue answers these without a turn.
// - Reset empties the queue; the block takes requests right after it.
// - A stalled receiver is absorbed by a two-word output buffer; it holds
//   requests off only while the buffer's second word is occupied.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int ID_BITS       = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH);

	// Chain taps
	logic                     cell_v    [DEPTH];
	logic [ID_BITS-1:0]       cell_id   [DEPTH];
	logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
	logic                     cell_ge   [DEPTH];
	logic                     src_v     [DEPTH];
	logic [ID_BITS-1:0]       src_id    [DEPTH];
	logic [PRIORITY_BITS-1:0] src_prio  [DEPTH];
	cell_op_t                 cell_op;

	// Controller state
	fsm_t                     state_q, state_d;
	logic [SW-1:0]            step_q;
	logic                     found_q;
	logic [CW-1:0]            count_q;
	op_t                      key_op_q;
	logic [ID_BITS-1:0]       key_id_q;
	logic [ID_BITS-1:0]       cap_id_q;
	logic [PRIORITY_BITS-1:0] cap_prio_q;

	// Output buffer
	logic                     main_v_q, skid_v_q;
	status_t                  main_st_q, skid_st_q;
	logic [ID_BITS-1:0]       main_id_q, skid_id_q;
	logic [PRIORITY_BITS-1:0] main_prio_q, skid_prio_q;

	logic                     acc, pop, push, hit, last_step, full, empty, start_scan;
	op_t                      op_in;
	status_t                  res_st;
	logic [ID_BITS-1:0]       res_id;
	logic [PRIORITY_BITS-1:0] res_prio;

	assign op_in     = op_t'(req.opcode);
	assign acc       = req.valid && req.ready;
	assign pop       = rsp.valid && rsp.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign last_step = (step_q == SW'(DEPTH - 1));

	// Front cell matches the target of the scan
	always_comb begin
		hit = 1'b0;
		if (state_q == S_SCAN && !found_q && cell_v[0]) begin
			if (key_op_q == OP_POP_LOW) begin
				hit = ((CW'(step_q) + CW'(1)) == count_q);
			end else begin
				hit = (cell_id[0] == key_id_q);
			end
		end
	end

	// Build the chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_tail
			// Close the ring until the target drops out
			assign src_v[i]    = (state_q == S_SCAN) && !found_q && !hit && cell_v[0];
			assign src_id[i]   = cell_id[0];
			assign src_prio[i] = cell_prio[0];
		end else if (i == DEPTH - 2) begin : g_wrap
			// After the drop the ring closes one slot earlier
			assign src_v[i]    = (state_q == S_SCAN && found_q) ? cell_v[0] : cell_v[i+1];
			assign src_id[i]   = (state_q == S_SCAN && found_q) ? cell_id[0] : cell_id[i+1];
			assign src_prio[i] = (state_q == S_SCAN && found_q) ? cell_prio[0]
				: cell_prio[i+1];
		end else begin : g_mid
			assign src_v[i]    = cell_v[i+1];
			assign src_id[i]   = cell_id[i+1];
			assign src_prio[i] = cell_prio[i+1];
		end

		if (i == 0) begin : g_head
			spq_cell #(
				.ID_BITS       (ID_BITS),
				.PRIORITY_BITS (PRIORITY_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (cell_op),
				.new_id      (req.item_id),
				.new_prio    (req.priority_req),
				.left_ge     (1'b1),
				.left_valid  (1'b1),
				.left_id     (req.item_id),
				.left_prio   (req.priority_req),
				.right_valid (src_v[i]),
				.right_id    (src_id[i]),
				.right_prio  (src_prio[i]),
				.valid       (cell_v[i]),
				.id          (cell_id[i]),
				.prio        (cell_prio[i]),
				.ge          (cell_ge[i])
			);
		end else begin : g_body
			spq_cell #(
				.ID_BITS       (ID_BITS),
				.PRIORITY_BITS (PRIORITY_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (cell_op),
				.new_id      (req.item_id),
				.new_prio    (req.priority_req),
				.left_ge     (cell_ge[i-1]),
				.left_valid  (cell_v[i-1]),
				.left_id     (cell_id[i-1]),
				.left_prio   (cell_prio[i-1]),
				.right_valid (src_v[i]),
				.right_id    (src_id[i]),
				.right_prio  (src_prio[i]),
				.valid       (cell_v[i]),
				.id          (cell_id[i]),
				.prio        (cell_prio[i]),
				.ge          (cell_ge[i])
			);
		end
	end

	// Next state, chain command and response word
	always_comb begin
		state_d    = state_q;
		cell_op    = CELL_HOLD;
		push       = 1'b0;
		start_scan = 1'b0;
		res_st     = STAT_OK;
		res_id     = '0;
		res_prio   = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (op_in)
						OP_INSERT: begin
							push = 1'b1;
							if (full) begin
								res_st = STAT_FULL;
							end else begin
								cell_op = CELL_INSERT;
							end
						end
						OP_POP_HIGH: begin
							push = 1'b1;
							if (empty) begin
								res_st = STAT_EMPTY;
							end else begin
								cell_op  = CELL_SHIFT;
								res_id   = cell_id[0];
								res_prio = cell_prio[0];
							end
						end
						default: begin
							if (empty) begin
								push   = 1'b1;
								res_st = STAT_EMPTY;
							end else begin
								start_scan = 1'b1;
								state_d    = S_SCAN;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				cell_op = CELL_SHIFT;
				if (last_step) begin
					push    = 1'b1;
					state_d = S_IDLE;
					if (found_q) begin
						res_id   = cap_id_q;
						res_prio = cap_prio_q;
					end else if (hit) begin
						res_id   = cell_id[0];
						res_prio = cell_prio[0];
					end else begin
						res_st = STAT_NOT_FOUND;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, scan position and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			found_q  <= 1'b0;
			count_q  <= '0;
			key_op_q <= OP_INSERT;
		end else begin
			state_q <= state_d;
			if (start_scan) begin
				step_q   <= '0;
				found_q  <= 1'b0;
				key_op_q <= op_in;
			end else if (state_q == S_SCAN) begin
				step_q <= step_q + SW'(1);
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (cell_op == CELL_INSERT) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == S_IDLE && cell_op == CELL_SHIFT) || hit) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Latch the search key and capture the dropped entry
	always_ff @(posedge clk) begin
		if (start_scan) begin
			key_id_q <= req.item_id;
		end
		if (hit) begin
			cap_id_q   <= cell_id[0];
			cap_prio_q <= cell_prio[0];
		end
	end

	// Advance the output buffer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (push) begin
					main_v_q <= 1'b1;
				end else if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					main_v_q <= 1'b0;
				end
			end else if (push) begin
				if (main_v_q) begin
					skid_v_q <= 1'b1;
				end else begin
					main_v_q <= 1'b1;
				end
			end
		end
	end

	// Move response words through the buffer
	always_ff @(posedge clk) begin
		if (pop) begin
			if (push) begin
				main_st_q   <= res_st;
				main_id_q   <= res_id;
				main_prio_q <= res_prio;
			end else if (skid_v_q) begin
				main_st_q   <= skid_st_q;
				main_id_q   <= skid_id_q;
				main_prio_q <= skid_prio_q;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_st_q   <= res_st;
				skid_id_q   <= res_id;
				skid_prio_q <= res_prio;
			end else begin
				main_st_q   <= res_st;
				main_id_q   <= res_id;
				main_prio_q <= res_prio;
			end
		end
	end

	assign req.ready        = (state_q == S_IDLE) && !skid_v_q;
	assign rsp.valid        = main_v_q;
	assign rsp.status       = main_st_q;
	assign rsp.out_id       = main_id_q;
	assign rsp.out_priority = main_prio_q;

endmodule

>>> tb/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: prediction and comparison for the sorted priority queue
// Watches the request and response channels and keeps its own sorted copy of
// the queue. Each request word yields one predicted response. Every response
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int ID_BITS       = 16
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	output int   errors,
	output int   pending,
	output int   words_checked,
	output int   full_hits,
	output int   empty_hits,
	output int   miss_hits
);

	typedef struct packed {
		status_t                  status;
		logic [ID_BITS-1:0]       id;
		logic [PRIORITY_BITS-1:0] prio;
	} outcome_t;

	// Shadow queue, slot 0 holds the highest priority
	logic [ID_BITS-1:0]       entry_id   [DEPTH];
	logic [PRIORITY_BITS-1:0] entry_prio [DEPTH];
	int                       entry_total;
	outcome_t                 awaited_outcomes[$];

	// Pull the entry at pos out of the shadow queue and close the gap
	function automatic outcome_t take_entry(int pos);
		outcome_t res;
		int       i;
		res.status = STAT_OK;
		res.id     = entry_id[pos];
		res.prio   = entry_prio[pos];
		for (i = pos; i + 1 < entry_total; i++) begin
			entry_id[i]   = entry_id[i + 1];
			entry_prio[i] = entry_prio[i + 1];
		end
		entry_total--;
		return res;
	endfunction

	// Apply one request word to the shadow queue and return its response
	function automatic outcome_t serve_request(op_t op, logic [ID_BITS-1:0] id,
		logic [PRIORITY_BITS-1:0] prio);
		outcome_t res;
		int       pos;
		int       i;
		res.status = STAT_OK;
		res.id     = '0;
		res.prio   = '0;
		if (op == OP_INSERT) begin
			if (entry_total >= DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				// go behind every entry of equal or higher priority
				pos = 0;
				while (pos < entry_total && entry_prio[pos] >= prio)
					pos++;
				for (i = entry_total; i > pos; i--) begin
					entry_id[i]   = entry_id[i - 1];
					entry_prio[i] = entry_prio[i - 1];
				end
				entry_id[pos]   = id;
				entry_prio[pos] = prio;
				entry_total++;
			end
		end else if (entry_total == 0) begin
			res.status = STAT_EMPTY;
		end else if (op == OP_POP_HIGH) begin
			res = take_entry(0);
		end else if (op == OP_POP_LOW) begin
			res = take_entry(entry_total - 1);
		end else begin
			// first match from the front wins
			pos = 0;
			while (pos < entry_total && entry_id[pos] != id)
				pos++;
			if (pos < entry_total)
				res = take_entry(pos);
			else
				res.status = STAT_NOT_FOUND;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		int       bad;
		if (!arst_n) begin
			entry_total = 0;
			awaited_outcomes.delete();
			errors        <= 0;
			pending       <= 0;
			words_checked <= 0;
			full_hits     <= 0;
			empty_hits    <= 0;
			miss_hits     <= 0;
		end else begin
			bad = 0;
			// check the response word against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (awaited_outcomes.size() == 0) begin
					$error("response word with no request waiting: status %0d out_id %h",
						rsp.status, rsp.out_id);
					bad++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (rsp.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, rsp.status);
						bad++;
					end
					if (rsp.out_id !== want.id) begin
						$error("out_id expected %h actual %h", want.id, rsp.out_id);
						bad++;
					end
					if (rsp.out_priority !== want.prio) begin
						$error("out_priority expected %h actual %h", want.prio,
							rsp.out_priority);
						bad++;
					end
				end
				words_checked <= words_checked + 1;
				case (status_t'(rsp.status))
					STAT_FULL:      full_hits  <= full_hits + 1;
					STAT_EMPTY:     empty_hits <= empty_hits + 1;
					STAT_NOT_FOUND: miss_hits  <= miss_hits + 1;
					default: ;
				endcase
			end
			// predict the response of an accepted request word
			if (req.valid && req.ready)
				awaited_outcomes.push_back(serve_request(op_t'(req.opcode), req.item_id,
					req.priority_req));
			errors  <= errors + bad;
			pending <= awaited_outcomes.size();
		end
	end

endmodule

>>> tb/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: testbench of the sorted priority queue
// Drives a directed pass over empty, full, tie, duplicate-id and miss cases,
// then bursts of fill-heavy and drain-heavy random operations under three
// idling mixes on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int PRIORITY_BITS  = 8;
	localparam int ID_BITS        = 16;
	localparam int PHASE_WORDS    = 170;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = DEPTH + 8;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   stall_cycles = 0;
	int   errors;
	int   pending;
	int   words_checked;
	int   full_hits;
	int   empty_hits;
	int   miss_hits;
	int   sent_insert = 0;
	int   sent_pop    = 0;
	int   sent_remove = 0;

	spq_req_if #(.ID_BITS(ID_BITS), .PRIORITY_BITS(PRIORITY_BITS)) req ();
	spq_rsp_if #(.ID_BITS(ID_BITS), .PRIORITY_BITS(PRIORITY_BITS)) rsp ();

	sorted_priority_queue #(
		.DEPTH(DEPTH),
		.PRIORITY_BITS(PRIORITY_BITS),
		.ID_BITS(ID_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	spq_checker #(
		.DEPTH(DEPTH),
		.PRIORITY_BITS(PRIORITY_BITS),
		.ID_BITS(ID_BITS)
	) monitor_u (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.errors(errors),
		.pending(pending),
		.words_checked(words_checked),
		.full_hits(full_hits),
		.empty_hits(empty_hits),
		.miss_hits(miss_hits)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Stall the response channel at the current rate
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// End the run if neither channel moves a word for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Offer one request word after a random gap and hold it until taken
	task automatic send_word(op_t op, logic [ID_BITS-1:0] id, logic [PRIORITY_BITS-1:0] prio);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid        <= 1'b0;
			req.opcode       <= 2'($urandom_range(3));
			req.item_id      <= ID_BITS'($urandom);
			req.priority_req <= PRIORITY_BITS'($urandom);
			@(negedge clk);
		end
		req.valid        <= 1'b1;
		req.opcode       <= op;
		req.item_id      <= id;
		req.priority_req <= prio;
		do
			@(posedge clk);
		while (!req.ready);
		case (op)
			OP_INSERT: sent_insert++;
			OP_REMOVE: sent_remove++;
			default:   sent_pop++;
		endcase
	endtask

	// Alternate fill-heavy and drain-heavy bursts so the queue swings
	// between empty and full; ids come mostly from a small pool so that
	// removes find their target, priorities mostly tie
	task automatic random_phase(int count);
		int                       burst_left;
		bit                       filling;
		int                       roll;
		int                       n;
		op_t                      op;
		logic [ID_BITS-1:0]       id;
		logic [PRIORITY_BITS-1:0] prio;
		burst_left = 0;
		filling    = 1'b0;
		for (n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				filling    = ~filling;
				burst_left = $urandom_range(40, 8);
			end
			burst_left--;
			roll = $urandom_range(99);
			if (roll < (filling ? 85 : 15))
				op = OP_INSERT;
			else if (roll < (filling ? 90 : 43))
				op = OP_POP_HIGH;
			else if (roll < (filling ? 95 : 71))
				op = OP_POP_LOW;
			else
				op = OP_REMOVE;
			id   = ($urandom_range(3) == 0) ? ID_BITS'($urandom_range(16'hFFFF))
				: ID_BITS'($urandom_range(15));
			prio = ($urandom_range(2) == 0) ? PRIORITY_BITS'($urandom_range(255))
				: PRIORITY_BITS'($urandom_range(3));
			send_word(op, id, prio);
		end
	endtask

	initial begin
		int k;
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.opcode       = OP_INSERT;
		req.item_id      = '0;
		req.priority_req = '0;
		tx_idle_pct      = 27;
		rx_idle_pct      = 55;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// pop and remove on an empty queue
		send_word(OP_POP_HIGH, 16'h0000, 8'h00);
		send_word(OP_POP_LOW, 16'hFFFF, 8'hFF);
		send_word(OP_REMOVE, 16'h0000, 8'h00);

		// fill to capacity: extremes, a three-way tie, duplicate ids, a spread
		send_word(OP_INSERT, 16'h0000, 8'h00);
		send_word(OP_INSERT, 16'hFFFF, 8'hFF);
		send_word(OP_INSERT, 16'h0001, 8'h05);
		send_word(OP_INSERT, 16'h0002, 8'h05);
		send_word(OP_INSERT, 16'h0003, 8'h05);
		send_word(OP_INSERT, 16'h0007, 8'h0A);
		send_word(OP_INSERT, 16'h0007, 8'h14);
		for (k = 0; k < 9; k++)
			send_word(OP_INSERT, ID_BITS'(16'h0100 + k), PRIORITY_BITS'(k * 28));

		// insert into a full queue, then take entries out from every end
		send_word(OP_INSERT, 16'hAAAA, 8'h80);
		send_word(OP_POP_HIGH, 16'h0000, 8'h00);
		send_word(OP_REMOVE, 16'h0007, 8'h00);
		send_word(OP_REMOVE, 16'h1234, 8'h00);
		send_word(OP_POP_LOW, 16'h0000, 8'h00);
		send_word(OP_REMOVE, 16'h0002, 8'h00);

		// random bursts under three idling mixes
		random_phase(PHASE_WORDS);
		tx_idle_pct = 55;
		rx_idle_pct = 27;
		random_phase(PHASE_WORDS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(PHASE_WORDS);

		// drop valid, wait out the remaining responses and a quiet tail
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request words: %0d inserts, %0d pops, %0d removes",
			sent_insert + sent_pop + sent_remove, sent_insert, sent_pop, sent_remove);
		$display("Checked %0d response words: %0d full drops, %0d empty, %0d id misses",
			words_checked, full_hits, empty_hits, miss_hits);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
hdl/spq_pkg.sv
hdl/spq_req_if.sv
hdl/spq_rsp_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue.sv
